// File: rtl/core/rc4kc_pkg.sv
// Shared types and constants for the RC4 keystream cipher engine.
package rc4kc_pkg;

	// Fixed geometry of the cipher state and key storage.
	localparam int unsigned PERM_ENTRIES  = 256;
	localparam int unsigned PERM_AW       = $clog2(PERM_ENTRIES);
	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned KEY_WORD_W    = 64;
	localparam int unsigned KEY_LEN_W     = 5;
	localparam int unsigned MAX_KEY_BYTES = 16;
	localparam int unsigned KIDX_W        = $clog2(MAX_KEY_BYTES);
	localparam int unsigned CFG_IDX_W     = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd2;

	localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd16;

	// Input command codes.
	localparam logic CMD_INIT = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	// Datapath operation issued by the controller for the current cycle.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_FILL,
		OP_KS_RD_A,
		OP_KS_RD_B,
		OP_KS_WR_A,
		OP_KS_WR_B,
		OP_GEN_RD_I,
		OP_GEN_RD_J,
		OP_GEN_WR_I,
		OP_GEN_WR_J,
		OP_GEN_OUT
	} dp_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		dp_op_t op;
		logic   start;
		logic   start_init;
		logic   out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic ctr_last;
	} dp_status_t;

endpackage

// File: rtl/core/rc4_keystream_cipher.sv
// Top level: a data byte passes through the keystream steps into the result register; one at a time.
// The next item is taken only once the result is loaded; a result waiting downstream delays this.
// Initialize makes 256 fill writes, then 256 schedule steps of two reads and two writes each,
// as the permutation memory has a single write port. It produces no result.
// Reset clears indices, handshakes and key registers (key length 16); the permutation
// memory holds nothing until an initialize transfer.
module rc4_keystream_cipher (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [rc4kc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rc4kc_pkg::KEY_WORD_W-1:0]    cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                cmd,
	input  logic [rc4kc_pkg::BYTE_W-1:0]        data_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [rc4kc_pkg::BYTE_W-1:0]        data_out
);
	import rc4kc_pkg::*;

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	// Sequencer.
	rc4kc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_cmd    (dp_cmd),
		.dp_status (dp_status)
	);

	// Storage and arithmetic.
	rc4kc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.data_in   (data_in),
		.dp_cmd    (dp_cmd),
		.dp_status (dp_status),
		.data_out  (data_out)
	);

	// An accepted transfer always makes the block busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after a transfer");

	// A data transfer is followed by its result being presented.
	a_data_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (cmd == CMD_DATA)) |-> ##6 out_valid)
		else $error("data result missing");

	// While the input is open, the datapath issues no operation.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> (dp_cmd.op == OP_NONE))
		else $error("datapath active while idle");

endmodule

// File: rtl/core/rc4kc_datapath.sv
// Datapath: key registers, permutation memory, indices and output register.
module rc4kc_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [rc4kc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rc4kc_pkg::KEY_WORD_W-1:0]  cfg_wdata,
	input  logic [rc4kc_pkg::BYTE_W-1:0]      data_in,
	input  rc4kc_pkg::dp_cmd_t                dp_cmd,
	output rc4kc_pkg::dp_status_t             dp_status,
	output logic [rc4kc_pkg::BYTE_W-1:0]      data_out
);
	import rc4kc_pkg::*;

	logic [KEY_WORD_W-1:0]   key_low_q;
	logic [KEY_WORD_W-1:0]   key_high_q;
	logic [KEY_LEN_W-1:0]    key_length_q;
	logic [2*KEY_WORD_W-1:0] key_all;
	logic [KEY_LEN_W-1:0]    eff_len;
	logic                    kidx_last;
	logic [BYTE_W-1:0]       key_byte;

	logic [BYTE_W-1:0]       perm_mem [PERM_ENTRIES];
	logic [BYTE_W-1:0]       rdata_q;
	logic                    mem_we;
	logic [PERM_AW-1:0]      mem_waddr;
	logic [BYTE_W-1:0]       mem_wdata;
	logic                    rd_en;
	logic [PERM_AW-1:0]      rd_addr;

	logic [PERM_AW-1:0]      ctr_q;
	logic [KIDX_W-1:0]       kidx_q;
	logic [PERM_AW-1:0]      i_q;
	logic [PERM_AW-1:0]      j_q;
	logic [BYTE_W-1:0]       t_q;
	logic [BYTE_W-1:0]       u_q;
	logic [BYTE_W-1:0]       din_q;
	logic [BYTE_W-1:0]       data_out_q;

	logic [PERM_AW-1:0]      j_sched;
	logic [PERM_AW-1:0]      j_gen;
	logic [PERM_AW-1:0]      i_next;
	logic [PERM_AW-1:0]      k_addr;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q    <= '0;
			key_high_q   <= '0;
			key_length_q <= KEY_LEN_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_KEY_LOW:    key_low_q    <= cfg_wdata;
				CFG_KEY_HIGH:   key_high_q   <= cfg_wdata;
				CFG_KEY_LENGTH: key_length_q <= cfg_wdata[KEY_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective key length: zero counts as one byte, large values saturate.
	always_comb begin
		if (key_length_q == '0) begin
			eff_len = KEY_LEN_W'(1);
		end else if (key_length_q > KEY_LEN_W'(MAX_KEY_BYTES)) begin
			eff_len = KEY_LEN_W'(MAX_KEY_BYTES);
		end else begin
			eff_len = key_length_q;
		end
	end

	// Current key byte, the key repeating cyclically.
	assign key_all   = {key_high_q, key_low_q};
	assign key_byte  = key_all[kidx_q*BYTE_W +: BYTE_W];
	assign kidx_last = (KEY_LEN_W'(kidx_q) == eff_len - KEY_LEN_W'(1));

	// Index arithmetic, all modulo the permutation size.
	assign j_sched = j_q + rdata_q + key_byte;
	assign j_gen   = j_q + rdata_q;
	assign i_next  = i_q + PERM_AW'(1);
	assign k_addr  = t_q + u_q;

	assign dp_status.ctr_last = (ctr_q == '1);

	// Memory port selection for each operation.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ctr_q;
		mem_wdata = ctr_q;
		rd_en     = 1'b0;
		rd_addr   = ctr_q;
		case (dp_cmd.op)
			OP_FILL: begin
				mem_we = 1'b1;
			end
			OP_KS_RD_A: begin
				rd_en = 1'b1;
			end
			OP_KS_RD_B: begin
				rd_en   = 1'b1;
				rd_addr = j_sched;
			end
			OP_KS_WR_A: begin
				mem_we    = 1'b1;
				mem_wdata = rdata_q;
			end
			OP_KS_WR_B: begin
				mem_we    = 1'b1;
				mem_waddr = j_q;
				mem_wdata = t_q;
			end
			OP_GEN_RD_I: begin
				rd_en   = 1'b1;
				rd_addr = i_next;
			end
			OP_GEN_RD_J: begin
				rd_en   = 1'b1;
				rd_addr = j_gen;
			end
			OP_GEN_WR_I: begin
				mem_we    = 1'b1;
				mem_waddr = i_q;
				mem_wdata = rdata_q;
			end
			OP_GEN_WR_J: begin
				mem_we    = 1'b1;
				mem_waddr = j_q;
				mem_wdata = t_q;
				rd_en     = 1'b1;
				rd_addr   = k_addr;
			end
			default: ;
		endcase
	end

	// Permutation memory with registered read; a read of the address being
	// written in the same cycle returns the new data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			perm_mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			if (mem_we && (mem_waddr == rd_addr)) begin
				rdata_q <= mem_wdata;
			end else begin
				rdata_q <= perm_mem[rd_addr];
			end
		end
	end

	// Counters and cipher indices.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q  <= '0;
			kidx_q <= '0;
			i_q    <= '0;
			j_q    <= '0;
		end else begin
			if (dp_cmd.start_init) begin
				ctr_q  <= '0;
				kidx_q <= '0;
				j_q    <= '0;
			end
			case (dp_cmd.op)
				OP_FILL: begin
					ctr_q <= ctr_q + PERM_AW'(1);
				end
				OP_KS_RD_B: begin
					j_q <= j_sched;
				end
				OP_KS_WR_B: begin
					ctr_q  <= ctr_q + PERM_AW'(1);
					kidx_q <= kidx_last ? '0 : kidx_q + KIDX_W'(1);
					if (dp_status.ctr_last) begin
						i_q <= '0;
						j_q <= '0;
					end
				end
				OP_GEN_RD_I: begin
					i_q <= i_next;
				end
				OP_GEN_RD_J: begin
					j_q <= j_gen;
				end
				default: ;
			endcase
		end
	end

	// Swap holding registers, input byte and result register.
	always_ff @(posedge clk) begin
		if (dp_cmd.start) begin
			din_q <= data_in;
		end
		if ((dp_cmd.op == OP_KS_RD_B) || (dp_cmd.op == OP_GEN_RD_J)) begin
			t_q <= rdata_q;
		end
		if (dp_cmd.op == OP_GEN_WR_I) begin
			u_q <= rdata_q;
		end
		if (dp_cmd.out_load) begin
			data_out_q <= din_q ^ rdata_q;
		end
	end

	assign data_out = data_out_q;

endmodule

// File: rtl/core/rc4kc_ctrl.sv
// Controller: sequences key schedule and keystream steps, owns the handshakes.
module rc4kc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	output logic                  out_valid,
	input  logic                  out_stall,
	output rc4kc_pkg::dp_cmd_t    dp_cmd,
	input  rc4kc_pkg::dp_status_t dp_status
);
	import rc4kc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_KS_RD_A,
		ST_KS_RD_B,
		ST_KS_WR_A,
		ST_KS_WR_B,
		ST_GEN_RD_I,
		ST_GEN_RD_J,
		ST_GEN_WR_I,
		ST_GEN_WR_J,
		ST_GEN_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   in_accept;
	logic   out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// Datapath commands decoded from the current state.
	always_comb begin
		dp_cmd.start      = in_accept;
		dp_cmd.start_init = in_accept && (cmd == CMD_INIT);
		dp_cmd.out_load   = (state_q == ST_GEN_OUT) && out_free;
		case (state_q)
			ST_FILL:     dp_cmd.op = OP_FILL;
			ST_KS_RD_A:  dp_cmd.op = OP_KS_RD_A;
			ST_KS_RD_B:  dp_cmd.op = OP_KS_RD_B;
			ST_KS_WR_A:  dp_cmd.op = OP_KS_WR_A;
			ST_KS_WR_B:  dp_cmd.op = OP_KS_WR_B;
			ST_GEN_RD_I: dp_cmd.op = OP_GEN_RD_I;
			ST_GEN_RD_J: dp_cmd.op = OP_GEN_RD_J;
			ST_GEN_WR_I: dp_cmd.op = OP_GEN_WR_I;
			ST_GEN_WR_J: dp_cmd.op = OP_GEN_WR_J;
			ST_GEN_OUT:  dp_cmd.op = OP_GEN_OUT;
			default:     dp_cmd.op = OP_NONE;
		endcase
	end

	// State register and result-valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (dp_cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= (cmd == CMD_INIT) ? ST_FILL : ST_GEN_RD_I;
					end
				end
				ST_FILL: begin
					if (dp_status.ctr_last) begin
						state_q <= ST_KS_RD_A;
					end
				end
				ST_KS_RD_A: state_q <= ST_KS_RD_B;
				ST_KS_RD_B: state_q <= ST_KS_WR_A;
				ST_KS_WR_A: state_q <= ST_KS_WR_B;
				ST_KS_WR_B: begin
					state_q <= dp_status.ctr_last ? ST_IDLE : ST_KS_RD_A;
				end
				ST_GEN_RD_I: state_q <= ST_GEN_RD_J;
				ST_GEN_RD_J: state_q <= ST_GEN_WR_I;
				ST_GEN_WR_I: state_q <= ST_GEN_WR_J;
				ST_GEN_WR_J: state_q <= ST_GEN_OUT;
				ST_GEN_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
